[sv/psu_pkg.sv]
`timescale 1ns / 1ps

package psu_pkg;

    // Default sizes
    localparam int MAX_LINE_BYTES_DEF = 16384;
    localparam int MAX_BPP_DEF        = 4;

    // Register port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int LINE_W     = 15;
    localparam int BPP_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = 1'd1;

    // Filter type codes
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

endpackage

[sv/psu_ram.sv]
`timescale 1ns / 1ps

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/psu_recon.sv]
`timescale 1ns / 1ps

module psu_recon (
    input  logic [7:0] i_kind,
    input  logic [7:0] i_raw,
    input  logic [7:0] i_left,
    input  logic [7:0] i_above,
    input  logic [7:0] i_upleft,
    output logic [7:0] o_result,
    output logic       o_bad
);
    import psu_pkg::*;

    logic signed [9:0] w_d_bc;
    logic signed [9:0] w_d_ac;
    logic signed [9:0] w_d_abc;
    logic        [9:0] w_pa;
    logic        [9:0] w_pb;
    logic        [9:0] w_pc;
    logic        [7:0] w_paeth;
    logic        [8:0] w_avg_sum;

    // Paeth distances: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
    assign w_d_bc  = $signed({2'b00, i_above}) - $signed({2'b00, i_upleft});
    assign w_d_ac  = $signed({2'b00, i_left}) - $signed({2'b00, i_upleft});
    assign w_d_abc = w_d_bc + w_d_ac;
    assign w_pa    = w_d_bc[9]  ? 10'(-w_d_bc)  : 10'(w_d_bc);
    assign w_pb    = w_d_ac[9]  ? 10'(-w_d_ac)  : 10'(w_d_ac);
    assign w_pc    = w_d_abc[9] ? 10'(-w_d_abc) : 10'(w_d_abc);

    // Pick the nearest predictor, ties to left then above
    always_comb begin
        if (w_pa <= w_pb && w_pa <= w_pc) begin
            w_paeth = i_left;
        end else if (w_pb <= w_pc) begin
            w_paeth = i_above;
        end else begin
            w_paeth = i_upleft;
        end
    end

    assign w_avg_sum = {1'b0, i_left} + {1'b0, i_above};

    // Apply the filter, mod 256; an unknown type gives zero and flags bad
    always_comb begin
        o_bad = 1'b0;
        unique case (i_kind)
            FILT_NONE:  o_result = i_raw;
            FILT_SUB:   o_result = i_raw + i_left;
            FILT_UP:    o_result = i_raw + i_above;
            FILT_AVG:   o_result = i_raw + w_avg_sum[8:1];
            FILT_PAETH: o_result = i_raw + w_paeth;
            default: begin
                o_result = 8'd0;
                o_bad    = 1'b1;
            end
        endcase
    end

endmodule

[sv/png_scanline_unfilter_core.sv]
`timescale 1ns / 1ps
// A data byte goes through the reconstruct stage, where the prior row is read at
// acceptance, and then into the output register. Throughput: one byte per cycle
// unless the output stalls, filter bytes included; the rate is set by the
// read-modify-write of the prior-row memory (one read and one write port).
// Reset: synchronous, active low; control and histories clear, the prior-row
// memory is not cleared and the first row of an image reads zero above.
module png_scanline_unfilter_core #(
    parameter int MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_BPP        = psu_pkg::MAX_BPP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_raw_byte,
    input  logic                           i_image_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_pixel_byte,
    output logic                           o_line_end,
    output logic                           o_bad_filter
);
    import psu_pkg::*;

    localparam int AW = $clog2(MAX_LINE_BYTES);
    localparam int LW = $clog2(MAX_LINE_BYTES + 1);
    localparam int CW = (LW > LINE_W) ? LW : LINE_W;
    localparam int HW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int BW = BPP_W + 1;

    // Configuration
    logic [LINE_W-1:0] r_line_bytes;
    logic [BPP_W-1:0]  r_bpp;

    // Line control
    logic [AW-1:0] r_column;
    logic [7:0]    r_kind;
    logic          r_await;
    logic          r_first_row;

    // Neighbor histories
    logic [7:0] r_left   [MAX_BPP];
    logic [7:0] r_upleft [MAX_BPP];

    // Reconstruct stage
    logic          r_s1_valid;
    logic [7:0]    r_s1_raw;
    logic [7:0]    r_s1_kind;
    logic          r_s1_zero_above;
    logic          r_s1_last;
    logic [AW-1:0] r_s1_addr;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic       r_out_last;
    logic       r_out_bad;

    logic          w_in_acc;
    logic          w_data_acc;
    logic          w_filt_acc;
    logic          w_s1_move;
    logic [CW-1:0] w_len_raw;
    logic [CW-1:0] w_eff_len;
    logic          w_last;
    logic [BW-1:0] w_bpp_raw;
    logic [BW-1:0] w_eff_bpp;
    logic [HW-1:0] w_hidx;
    logic [7:0]    w_rdata;
    logic [7:0]    w_above;
    logic [7:0]    w_result;
    logic          w_bad;
    logic [AW-1:0] n_column;

    // Handshake
    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_data_acc = w_in_acc && !r_await;
    assign w_filt_acc = w_in_acc && r_await;

    // Clamp line length and pixel size
    assign w_len_raw = CW'(r_line_bytes);
    assign w_eff_len = (w_len_raw == '0) ? CW'(1) :
                       (w_len_raw > CW'(MAX_LINE_BYTES)) ? CW'(MAX_LINE_BYTES) : w_len_raw;
    assign w_last    = (CW'(r_column) + CW'(1)) >= w_eff_len;
    assign n_column  = w_last ? '0 : r_column + AW'(1);

    assign w_bpp_raw = {1'b0, r_bpp};
    assign w_eff_bpp = (w_bpp_raw == '0) ? BW'(1) :
                       (w_bpp_raw > BW'(MAX_BPP)) ? BW'(MAX_BPP) : w_bpp_raw;
    assign w_hidx    = HW'(w_eff_bpp - BW'(1));

    // Previous-row store
    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_prior_row (
        .i_clk   (i_clk),
        .i_we    (w_s1_move),
        .i_waddr (r_s1_addr),
        .i_wdata (w_result),
        .i_re    (w_data_acc),
        .i_raddr (r_column),
        .o_rdata (w_rdata)
    );

    assign w_above = r_s1_zero_above ? 8'd0 : w_rdata;

    psu_recon u_recon (
        .i_kind   (r_s1_kind),
        .i_raw    (r_s1_raw),
        .i_left   (r_left[w_hidx]),
        .i_above  (w_above),
        .i_upleft (r_upleft[w_hidx]),
        .o_result (w_result),
        .o_bad    (w_bad)
    );

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= LINE_W'(1);
            r_bpp        <= BPP_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINE_BYTES: r_line_bytes <= i_cfg_data[LINE_W-1:0];
                REG_BPP:        r_bpp        <= i_cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance line control on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_kind      <= FILT_NONE;
            r_await     <= 1'b1;
            r_first_row <= 1'b1;
        end else if (w_filt_acc) begin
            r_kind   <= i_raw_byte;
            r_await  <= 1'b0;
            r_column <= '0;
            if (i_image_start) begin
                r_first_row <= 1'b1;
            end
        end else if (w_data_acc) begin
            r_column <= n_column;
            if (w_last) begin
                r_await     <= 1'b1;
                r_first_row <= 1'b0;
            end
        end
    end

    // Load the reconstruct stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_data_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_acc) begin
            r_s1_raw        <= i_raw_byte;
            r_s1_kind       <= r_kind;
            r_s1_zero_above <= r_first_row;
            r_s1_last       <= w_last;
            r_s1_addr       <= r_column;
        end
    end

    // Push histories as a byte retires; a filter byte clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_filt_acc) begin
            for (int i = 0; i < MAX_BPP; i++) begin
                r_left[i]   <= 8'd0;
                r_upleft[i] <= 8'd0;
            end
        end else if (w_s1_move) begin
            r_left[0]   <= w_result;
            r_upleft[0] <= w_above;
            for (int i = 1; i < MAX_BPP; i++) begin
                r_left[i]   <= r_left[i-1];
                r_upleft[i] <= r_upleft[i-1];
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_pixel <= w_result;
            r_out_last  <= r_s1_last;
            r_out_bad   <= w_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_pixel;
    assign o_line_end   = r_out_last;
    assign o_bad_filter = r_out_bad;

    // Prior-row read never collides with the write-back of the same column
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && w_data_acc) |-> (r_s1_addr != r_column))
        else $error("prior-row read and write hit the same column");

    // The last byte of a line in flight means the next request is a filter byte
    a_last_awaits_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_await)
        else $error("line ended without awaiting a filter byte");

    // A bad filter delivers a zero byte
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_pixel == 8'd0))
        else $error("bad filter result is not zero");

    // A filter request retires no byte
    a_filter_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_filt_acc && !w_s1_move) |=> (r_s1_valid == $past(r_s1_valid)))
        else $error("filter byte changed the reconstruct stage");

endmodule

[tb/sv/unfilter_monitor.sv]
`timescale 1ns / 1ps

module unfilter_monitor #(
    parameter int MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_BPP        = psu_pkg::MAX_BPP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_raw_byte,
    input  logic                           i_image_start,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     i_pixel_byte,
    input  logic                           i_line_end,
    input  logic                           i_bad_filter,
    output int                             o_pending,
    output int                             o_fail_count
);
    import psu_pkg::*;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       line_end;
        logic       bad_filter;
    } t_pixel_result;

    t_pixel_result     expected_pixels[$];
    t_pixel_result     want_px;
    int                fail_total = 0;

    // Shadow of the block's line state
    logic [7:0]        prior_row   [MAX_LINE_BYTES];
    logic [7:0]        left_hist   [MAX_BPP];
    logic [7:0]        upleft_hist [MAX_BPP];
    int                column;
    logic [7:0]        filter_kind;
    logic              want_filter;
    logic              first_row;
    logic [LINE_W-1:0] line_bytes;
    logic [BPP_W-1:0]  pixel_bytes;

    // Pick the neighbor closest to left + above - upper-left, ties in that order
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int est, da, db, dc;
        est = int'(a) + int'(b) - int'(c);
        da  = est > int'(a) ? est - int'(a) : int'(a) - est;
        db  = est > int'(b) ? est - int'(b) : int'(b) - est;
        dc  = est > int'(c) ? est - int'(c) : int'(c) - est;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Advance the shadow state by one request, queue the byte it should produce
    task automatic reconstruct_byte(input logic [7:0] raw, input logic start);
        int         len, bpp, idx;
        logic [7:0] left, above, upleft, pixel;
        logic [8:0] pair_sum;
        logic       bad, last;
        len = (line_bytes == 0) ? 1 :
              (line_bytes > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(line_bytes);
        bpp = (pixel_bytes == 0) ? 1 :
              (pixel_bytes > MAX_BPP) ? MAX_BPP : int'(pixel_bytes);
        if (want_filter) begin
            filter_kind = raw;
            want_filter = 1'b0;
            column      = 0;
            foreach (left_hist[i]) begin
                left_hist[i]   = '0;
                upleft_hist[i] = '0;
            end
            if (start) first_row = 1'b1;
        end else begin
            idx      = column < MAX_LINE_BYTES ? column : MAX_LINE_BYTES - 1;
            left     = left_hist[bpp-1];
            upleft   = upleft_hist[bpp-1];
            above    = first_row ? 8'd0 : prior_row[idx];
            pair_sum = {1'b0, left} + {1'b0, above};
            bad      = 1'b0;
            case (filter_kind)
                FILT_NONE:  pixel = raw;
                FILT_SUB:   pixel = raw + left;
                FILT_UP:    pixel = raw + above;
                FILT_AVG:   pixel = raw + pair_sum[8:1];
                FILT_PAETH: pixel = raw + paeth_pick(left, above, upleft);
                default: begin
                    pixel = 8'd0;
                    bad   = 1'b1;
                end
            endcase
            prior_row[idx] = pixel;
            for (int i = MAX_BPP - 1; i > 0; i--) begin
                left_hist[i]   = left_hist[i-1];
                upleft_hist[i] = upleft_hist[i-1];
            end
            left_hist[0]   = pixel;
            upleft_hist[0] = above;
            last = (column + 1) >= len;
            if (last) begin
                want_filter = 1'b1;
                first_row   = 1'b0;
                column      = 0;
            end else begin
                column++;
            end
            expected_pixels.push_back('{pixel, last, bad});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
            foreach (left_hist[i]) begin
                left_hist[i]   = '0;
                upleft_hist[i] = '0;
            end
            column      = 0;
            filter_kind = '0;
            want_filter = 1'b1;
            first_row   = 1'b1;
            line_bytes  = LINE_W'(1);
            pixel_bytes = BPP_W'(1);
        end else begin
            // Compare the byte leaving the block with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    fail_total++;
                    $error("result with no request pending: pixel_byte %0h", i_pixel_byte);
                end else begin
                    want_px = expected_pixels.pop_front();
                    if (i_pixel_byte !== want_px.pixel_byte) begin
                        fail_total++;
                        $error("pixel_byte expected %0h got %0h",
                               want_px.pixel_byte, i_pixel_byte);
                    end
                    if (i_line_end !== want_px.line_end) begin
                        fail_total++;
                        $error("line_end expected %0b got %0b", want_px.line_end, i_line_end);
                    end
                    if (i_bad_filter !== want_px.bad_filter) begin
                        fail_total++;
                        $error("bad_filter expected %0b got %0b",
                               want_px.bad_filter, i_bad_filter);
                    end
                end
            end
            // Predict each accepted request
            if (i_in_valid && !i_in_stall) reconstruct_byte(i_raw_byte, i_image_start);
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LINE_BYTES: line_bytes  = i_cfg_data[LINE_W-1:0];
                    REG_BPP:        pixel_bytes = i_cfg_data[BPP_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import psu_pkg::*;

    localparam int SMALL_ITEMS  = 1660;
    localparam int QUIET_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_LINE     = MAX_LINE_BYTES_DEF;
    localparam int BIG_DATA     = 256;

    typedef enum int {FILL_EDGES, FILL_EDGES_START, FILL_RANDOM} t_fill_mode;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [7:0]            raw_byte    = '0;
    logic                  image_start = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [7:0]            pixel_byte;
    logic                  line_end;
    logic                  bad_filter;
    int                    pending;
    int                    fail_count;

    // Stream position as the block sees it, used to shape legal sequences
    int line_len     = 1;
    bit await_filter = 1'b1;
    int line_col     = 0;
    bit top_row      = 1'b1;
    int stored_cols  = 0;

    int items_sent  = 0;
    int big_items   = 0;
    bit big_done    = 1'b0;
    bit quiet       = 1'b0;
    bit held        = 1'b0;
    int cycle_count = 0;

    png_scanline_unfilter_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_raw_byte    (raw_byte),
        .i_image_start (image_start),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_byte  (pixel_byte),
        .o_line_end    (line_end),
        .o_bad_filter  (bad_filter)
    );

    unfilter_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_raw_byte    (raw_byte),
        .i_image_start (image_start),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_pixel_byte  (pixel_byte),
        .i_line_end    (line_end),
        .i_bad_filter  (bad_filter),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("png_scanline_unfilter_core: mismatch");
            $finish;
        end
    end

    function automatic int eff_len(input logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_LINE) return MAX_LINE;
        return int'(v);
    endfunction

    task automatic write_config(input bit set_len, input logic [CFG_DATA_W-1:0] len_val,
                                input bit set_bpp, input logic [CFG_DATA_W-1:0] bpp_val);
        if (set_len) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_LINE_BYTES;
            cfg_data <= len_val;
            @(posedge clk);
            line_len = eff_len(len_val);
        end
        if (set_bpp) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_BPP;
            cfg_data <= bpp_val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one request, with an optional idle burst first, and hold until taken
    task automatic send_byte(input logic [7:0] raw, input logic start);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        raw_byte    <= raw;
        image_start <= start;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (await_filter) begin
            await_filter = 1'b0;
            line_col     = 0;
            if (start) top_row = 1'b1;
        end else begin
            if (line_col + 1 > stored_cols) stored_cols = line_col + 1;
            if (line_col + 1 >= line_len) begin
                await_filter = 1'b1;
                top_row      = 1'b0;
                line_col     = 0;
            end else begin
                line_col++;
            end
        end
    endtask

    // Finish the open line or start a new one; stop after n_data data bytes
    task automatic send_line(input logic [7:0] kind, input bit new_image,
                             input t_fill_mode mode, input int n_data);
        int         sent;
        logic [7:0] data;
        logic       data_start;
        sent = 0;
        // Force a new image where the row above was never fully stored
        if (await_filter)
            send_byte(kind, new_image || (!top_row && line_len > stored_cols));
        while (!await_filter && sent < n_data) begin
            case (mode)
                FILL_EDGES, FILL_EDGES_START: begin
                    data       = line_col[0] ? 8'hFF : 8'h00;
                    data_start = (mode == FILL_EDGES_START);
                end
                default: begin
                    data = ($urandom_range(0, 3) == 0) ?
                           ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
                    data_start = ($urandom_range(0, 7) == 0);
                end
            endcase
            send_byte(data, data_start);
            sent++;
        end
    endtask

    // Drop valid and let the pipeline drain, filter bytes included
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall bursts, calm stretches, one long hold-off
    initial begin : receiver
        forever begin
            if (!held && items_sent >= 500 && in_valid) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else if ($urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] len_val, bpp_val;
        logic [7:0]            kind;
        bit                    set_len, set_bpp;
        int                    n_lines, start_mark;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every filter type, unknown types, edge data, ignored image start
        write_config(1'b1, 15'd2, 1'b1, 15'd1);
        send_line(FILT_NONE, 1'b1, FILL_EDGES, MAX_LINE);
        send_line(FILT_SUB, 1'b0, FILL_EDGES_START, MAX_LINE);
        send_line(FILT_UP, 1'b0, FILL_EDGES, MAX_LINE);
        send_line(FILT_AVG, 1'b0, FILL_EDGES, MAX_LINE);
        send_line(FILT_PAETH, 1'b0, FILL_EDGES, MAX_LINE);
        send_line(FILT_PAETH + 8'd1, 1'b0, FILL_EDGES, MAX_LINE);
        send_line(8'hFF, 1'b0, FILL_EDGES, MAX_LINE);
        // Zero length acts as one byte per line
        wait_idle();
        write_config(1'b1, 15'd0, 1'b0, 15'd0);
        send_line(FILT_UP, 1'b0, FILL_EDGES, MAX_LINE);

        // Random phases, each under its own register setting
        while (items_sent - big_items < SMALL_ITEMS) begin
            wait_idle();
            quiet = (items_sent - big_items) >= SMALL_ITEMS - QUIET_ITEMS;
            if (!big_done && items_sent >= 800 && await_filter) begin
                // Long line once, all length bits set; cut short mid-line by a shorter length
                big_done   = 1'b1;
                start_mark = items_sent;
                write_config(1'b1, 15'h7FFF, 1'b1, 15'($urandom_range(0, 7)));
                send_line(8'($urandom_range(FILT_NONE, FILT_PAETH)), 1'b1, FILL_RANDOM,
                          BIG_DATA);
                wait_idle();
                write_config(1'b1, 15'd8, 1'b0, 15'd0);
                send_line(FILT_PAETH, 1'b0, FILL_RANDOM, MAX_LINE);
                big_items = items_sent - start_mark;
            end else begin
                set_len = ($urandom_range(0, 3) != 0);
                set_bpp = ($urandom_range(0, 1) == 1);
                case ($urandom_range(0, 9))
                    0:       len_val = 15'd0;
                    1:       len_val = 15'd1;
                    default: len_val = 15'($urandom_range(2, 24));
                endcase
                // Mid-line, never grow past the stored part of the row above
                if (!await_filter && !top_row && eff_len(len_val) > stored_cols)
                    len_val = 15'($urandom_range(1, stored_cols));
                bpp_val = {12'($urandom), 3'($urandom)};
                write_config(set_len, len_val, set_bpp, bpp_val);
                n_lines = $urandom_range(1, 6);
                repeat (n_lines) begin
                    kind = ($urandom_range(0, 7) != 0) ?
                           8'($urandom_range(FILT_NONE, FILT_PAETH)) :
                           8'($urandom_range(FILT_PAETH + 1, 255));
                    send_line(kind, $urandom_range(0, 5) == 0, FILL_RANDOM, MAX_LINE);
                end
                // Leave a line open so the next setting lands mid-line
                if ($urandom_range(0, 3) == 0) begin
                    kind = 8'($urandom_range(FILT_NONE, FILT_PAETH));
                    send_line(kind, 1'b0, FILL_RANDOM, $urandom_range(0, line_len - 1));
                end
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("png_scanline_unfilter_core: match");
        else
            $display("png_scanline_unfilter_core: mismatch");
        $finish;
    end

endmodule
